### rtl/core/rope_pkg.sv
// ----------------------------------------------------------------------------
// rope_pkg
// Types, register indexes and fp32 / fp16 arithmetic helpers for the rotary
// embedding pair rotator pipeline.
// ----------------------------------------------------------------------------
package rope_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_OUTPUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERT_ONLY = 2'd1;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;

  // product between multiply, normalize and round stages
  typedef struct packed {
    logic               sp;
    logic [31:0]        spv;
    logic               sgn;
    logic signed [10:0] e;
    logic [47:0]        p;
  } mulp_t;

  // sum between align, normalize and round stages
  typedef struct packed {
    logic        sp;
    logic [31:0] spv;
    logic        sgn;
    logic        zsgn;
    logic [8:0]  e;
    logic        sub;
    logic [27:0] s;
  } addp_t;

  function automatic mulp_t fmul_pre(logic [31:0] a, logic [31:0] b);
    mulp_t r;
    logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [23:0] ma, mb;
    logic [7:0] ea, eb;
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    r.sgn  = a[31] ^ b[31];
    r.sp   = 1'b0;
    r.spv  = 32'd0;
    if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
      r.sp  = 1'b1;
      r.spv = QNAN32;
    end else if (inf_a || inf_b) begin
      r.sp  = 1'b1;
      r.spv = {r.sgn, 8'hFF, 23'd0};
    end
    ma  = {(a[30:23] != 8'd0), a[22:0]};
    mb  = {(b[30:23] != 8'd0), b[22:0]};
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    r.e = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
    r.p = ma * mb;
    return r;
  endfunction

  function automatic mulp_t fmul_norm(mulp_t m);
    mulp_t r;
    logic [5:0] lz;
    r  = m;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m.p[i]) lz = 6'(47 - i);
    end
    r.p = m.p << lz;
    r.e = m.e - $signed({5'b00000, lz});
    if (!m.sp && (m.p == 48'd0)) begin
      r.sp  = 1'b1;
      r.spv = {m.sgn, 31'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] fmul_round(mulp_t m);
    logic [47:0] ns, mask;
    logic [10:0] sh;
    logic [7:0]  ef;
    logic        stk, g, st, rnd;
    logic [23:0] m24;
    logic [30:0] bits;
    ns   = m.p;
    stk  = 1'b0;
    ef   = m.e[7:0];
    sh   = 11'd0;
    mask = 48'd0;
    if (m.e <= 11'sd0) begin
      sh = 11'(11'sd1 - m.e);
      ef = 8'd0;
      if (sh > 11'd47) begin
        ns  = 48'd0;
        stk = |m.p;
      end else begin
        ns   = m.p >> sh;
        mask = (48'h1 << sh) - 48'h1;
        stk  = |(m.p & mask);
      end
    end
    m24  = ns[47:24];
    g    = ns[23];
    st   = (|ns[22:0]) | stk;
    rnd  = g & (st | m24[0]);
    bits = {ef, 23'd0} + {8'd0, m24[22:0]} + {30'd0, rnd};
    if (m.sp) return m.spv;
    if (m.e >= 11'sd255) return {m.sgn, 8'hFF, 23'd0};
    return {m.sgn, bits};
  endfunction

  function automatic addp_t fadd_align(logic [31:0] x, logic [31:0] y);
    addp_t r;
    logic nan_x, nan_y, inf_x, inf_y, swap;
    logic [31:0] big, sml;
    logic [7:0] eb, es, d;
    logic [26:0] mbig, msml, sm, mask;
    logic stk;
    nan_x = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    nan_y = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    inf_x = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    inf_y = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    r.sp  = 1'b0;
    r.spv = 32'd0;
    if (nan_x || nan_y || (inf_x && inf_y && (x[31] != y[31]))) begin
      r.sp  = 1'b1;
      r.spv = QNAN32;
    end else if (inf_x) begin
      r.sp  = 1'b1;
      r.spv = x;
    end else if (inf_y) begin
      r.sp  = 1'b1;
      r.spv = y;
    end
    swap   = x[30:0] < y[30:0];
    big    = swap ? y : x;
    sml    = swap ? x : y;
    eb     = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es     = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d      = eb - es;
    mbig   = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    msml   = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    mask   = 27'd0;
    if (d > 8'd26) begin
      sm  = 27'd0;
      stk = |msml;
    end else begin
      sm   = msml >> d;
      mask = (27'h1 << d) - 27'h1;
      stk  = |(msml & mask);
    end
    sm[0]  = sm[0] | stk;
    r.sgn  = big[31];
    r.zsgn = x[31] & y[31];
    r.e    = {1'b0, eb};
    r.sub  = 1'b0;
    if (x[31] == y[31]) r.s = {1'b0, mbig} + {1'b0, sm};
    else                r.s = {1'b0, mbig} - {1'b0, sm};
    return r;
  endfunction

  function automatic addp_t fadd_norm(addp_t a);
    addp_t r;
    logic [4:0] lz;
    logic [8:0] lim, sh;
    r  = a;
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (a.s[i]) lz = 5'(26 - i);
    end
    lim = a.e - 9'd1;
    sh  = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
    if (a.s[27]) begin
      r.s = (a.s >> 1) | {27'd0, a.s[0]};
      r.e = a.e + 9'd1;
    end else begin
      r.s   = a.s << sh;
      r.e   = a.e - sh;
      r.sub = {4'd0, lz} > lim;
    end
    if (!a.sp && (a.s == 28'd0)) begin
      r.sp  = 1'b1;
      r.spv = {a.zsgn, 31'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] fadd_round(addp_t a);
    logic [23:0] m24;
    logic        g, st, rnd;
    logic [7:0]  ef;
    logic [30:0] bits;
    m24  = a.s[26:3];
    g    = a.s[2];
    st   = |a.s[1:0];
    rnd  = g & (st | m24[0]);
    ef   = a.sub ? 8'd0 : a.e[7:0];
    bits = {ef, 23'd0} + {8'd0, m24[22:0]} + {30'd0, rnd};
    if (a.sp) return a.spv;
    if (a.e >= 9'd255) return {a.sgn, 8'hFF, 23'd0};
    return {a.sgn, bits};
  endfunction

  function automatic logic [15:0] rne_shift(logic [23:0] m, logic [6:0] sh);
    logic [31:0] mm, q, rem, hw;
    mm  = {8'd0, m};
    q   = mm >> sh;
    rem = mm & ((32'h1 << sh) - 32'h1);
    hw  = 32'h1 << (sh - 7'd1);
    if ((rem > hw) || ((rem == hw) && q[0])) q = q + 32'd1;
    if (sh > 7'd25) return 16'd0;
    return q[15:0];
  endfunction

  function automatic logic [15:0] to_fp16(logic [31:0] x);
    logic [7:0]        ex;
    logic [22:0]       man;
    logic [23:0]       m;
    logic signed [9:0] e, shv, e14;
    logic [15:0]       h;
    ex  = x[30:23];
    man = x[22:0];
    m   = {1'b1, man};
    e   = $signed({2'b00, ex}) - 10'sd127;
    e14 = e + 10'sd14;
    shv = -10'sd1 - e;
    if (ex == 8'hFF) begin
      if (man != 23'd0) return {x[31], 15'h7E00 | {5'd0, man[22:13]}};
      return {x[31], 15'h7C00};
    end
    if (ex == 8'd0) return {x[31], 15'd0};
    if (e > 10'sd15) return {x[31], 15'h7C00};
    if (e >= -10'sd14) begin
      h = {1'b0, e14[4:0], 10'd0} + rne_shift(m, 7'd13);
      if (h >= 16'h7C00) h = 16'h7C00;
    end else begin
      h = (shv > 10'sd25) ? 16'd0 : rne_shift(m, shv[6:0]);
    end
    return {x[31], h[14:0]};
  endfunction

endpackage

### rtl/core/rope_if.sv
// ----------------------------------------------------------------------------
// rope_if
// Valid/ready channels of the rotary embedding pair rotator: input pair,
// rotated result and configuration write.
// ----------------------------------------------------------------------------
interface rope_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_in;
  logic [31:0] second_in;
  logic [31:0] cos_value;
  logic [31:0] sin_value;
  modport source (output valid, first_in, second_in, cos_value, sin_value, input ready);
  modport sink (input valid, first_in, second_in, cos_value, sin_value, output ready);
endinterface

interface rope_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_out;
  logic [31:0] second_out;
  modport source (output valid, first_out, second_out, input ready);
  modport sink (input valid, first_out, second_out, output ready);
endinterface

interface rope_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rope_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/rotary_embedding_pair_rotate_top.sv
// ----------------------------------------------------------------------------
// rotary_embedding_pair_rotate_top
// Rotates one fp32 embedding pair per beat by cos/sin, with optional fp16
// output and a convert-only pass.
// ----------------------------------------------------------------------------
// channel  dir  fields
// pair     in   first_in, second_in, cos_value, sin_value
// result   out  first_out, second_out
// cfg      in   index, data (0: half_output, 1: convert_only)
//
// Seven register stages: multiply, normalize, round products, align and add,
// normalize, round sums, fp16 convert into the output register.
// One beat per cycle while the output register is not held.
// The whole pipeline holds while the output register is full and not taken.
// Synchronous reset clears valid bits and both config registers.
// ----------------------------------------------------------------------------
module rotary_embedding_pair_rotate_top (
  input  logic      clk,
  input  logic      rst,
  rope_in_if.sink   pair,
  rope_out_if.source result,
  rope_cfg_if.sink  cfg
);
  import rope_pkg::*;

  logic half_output;
  logic convert_only;
  logic adv;
  logic [6:0] vld;

  logic [31:0] a1, b1, a2, b2, a3, b3, a4, b4, a5, b5, a6, b6;
  mulp_t m1 [4];
  mulp_t m2 [4];
  logic [31:0] p3 [4];
  addp_t s4 [2];
  addp_t s5 [2];
  logic [31:0] r6 [2];
  logic [31:0] src0, src1;
  logic [31:0] out0, out1;

  assign adv        = !vld[6] || result.ready;
  assign pair.ready = adv;
  assign cfg.ready  = 1'b1;
  assign result.valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      half_output  <= 1'b0;
      convert_only <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HALF_OUTPUT:  half_output  <= cfg.data[0];
        REG_CONVERT_ONLY: convert_only <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 7'd0;
    end else if (adv) begin
      vld <= {vld[5:0], pair.valid};
    end
  end

  always_comb begin
    src0 = convert_only ? a6 : r6[0];
    src1 = convert_only ? b6 : r6[1];
    out0 = src0;
    out1 = src1;
    if (convert_only || half_output) begin
      out0 = {16'd0, to_fp16(src0)};
      out1 = {16'd0, to_fp16(src1)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= pair.first_in;
      b1 <= pair.second_in;
      m1[0] <= fmul_pre(pair.first_in, pair.cos_value);
      m1[1] <= fmul_pre(pair.second_in, pair.sin_value);
      m1[2] <= fmul_pre(pair.first_in, pair.sin_value);
      m1[3] <= fmul_pre(pair.second_in, pair.cos_value);
      a2 <= a1; b2 <= b1;
      a3 <= a2; b3 <= b2;
      a4 <= a3; b4 <= b3;
      a5 <= a4; b5 <= b4;
      a6 <= a5; b6 <= b5;
      for (int i = 0; i < 4; i++) begin
        m2[i] <= fmul_norm(m1[i]);
        p3[i] <= fmul_round(m2[i]);
      end
      s4[0] <= fadd_align(p3[0], {~p3[1][31], p3[1][30:0]});
      s4[1] <= fadd_align(p3[2], p3[3]);
      for (int j = 0; j < 2; j++) begin
        s5[j] <= fadd_norm(s4[j]);
        r6[j] <= fadd_round(s5[j]);
      end
      result.first_out  <= out0;
      result.second_out <= out1;
    end
  end

endmodule

### bench/rotary_embedding_pair_rotate_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotary_embedding_pair_rotate_top_test
// Drives fp32 embedding pairs with cos/sin through the rotator under all
// register settings and random handshake gaps. A bit-exact integer model of
// fp32 multiply, add and fp16 conversion predicts each rotated pair, which is
// compared field by field with the result beats in order.
// ----------------------------------------------------------------------------
module rotary_embedding_pair_rotate_top_test;
  import rope_pkg::*;

  localparam int          HALF_PERIOD = 6;
  localparam longint      CYCLE_LIMIT = 400000;
  localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
  } rotated_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rope_in_if  pair_ch ();
  rope_out_if result_ch ();
  rope_cfg_if cfg_ch ();

  rotary_embedding_pair_rotate_top dut (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rotated_pair_t pending_pairs[$];
  logic          half_mode = 1'b0;
  logic          convert_mode = 1'b0;
  int            mismatches = 0;
  longint        cycles = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_left = 0;

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint unsigned shr_even(longint unsigned v, int sh);
    longint unsigned q, rem, halfway;
    if (sh <= 0) return v << (-sh);
    if (sh >= 64) return 64'd0;
    q       = v >> sh;
    rem     = v & ((64'd1 << sh) - 64'd1);
    halfway = 64'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && q[0])) q++;
    return q;
  endfunction

  // value is mant * 2^exp2, mant nonzero
  function automatic logic [31:0] pack_fp32(logic sgn, longint exp2, longint unsigned mant);
    int              msb;
    longint          sh;
    longint unsigned q;
    longint          bits;
    msb = 0;
    for (int i = 0; i < 64; i++) if (mant[i]) msb = i;
    sh = msb - 23;
    if (-149 - exp2 > sh) sh = -149 - exp2;
    q    = shr_even(mant, int'(sh));
    bits = ((exp2 + sh + 149) <<< 23) + longint'(q);
    if (bits >= 64'h7F80_0000) return {sgn, 8'hFF, 23'd0};
    return {sgn, bits[30:0]};
  endfunction

  function automatic logic is_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 23'd0;
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 23'd0;
  endfunction

  function automatic logic [31:0] fp32_mul(logic [31:0] a, logic [31:0] b);
    logic            sgn;
    longint unsigned ma, mb;
    longint          ea, eb;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return CANON_NAN;
      return {sgn, 8'hFF, 23'd0};
    end
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
    ma = 64'({a[30:23] != 8'd0, a[22:0]});
    mb = 64'({b[30:23] != 8'd0, b[22:0]});
    ea = (a[30:23] == 8'd0) ? 64'sd1 : longint'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 64'sd1 : longint'(b[30:23]);
    return pack_fp32(sgn, ea + eb - 300, ma * mb);
  endfunction

  function automatic logic [31:0] fp32_add(logic [31:0] x, logic [31:0] y);
    logic [31:0]     big, sml;
    longint unsigned mb, ms, sum;
    longint          eb, es, d, exp2;
    if (is_nan(x) || is_nan(y)) return CANON_NAN;
    if (is_inf(x) && is_inf(y) && x[31] != y[31]) return CANON_NAN;
    if (is_inf(x)) return x;
    if (is_inf(y)) return y;
    big = (x[30:0] >= y[30:0]) ? x : y;
    sml = (x[30:0] >= y[30:0]) ? y : x;
    mb  = 64'({big[30:23] != 8'd0, big[22:0]});
    ms  = 64'({sml[30:23] != 8'd0, sml[22:0]});
    eb  = (big[30:23] == 8'd0) ? 64'sd1 : longint'(big[30:23]);
    es  = (sml[30:23] == 8'd0) ? 64'sd1 : longint'(sml[30:23]);
    d   = eb - es;
    if (d <= 26) begin
      exp2 = es - 150;
      sum  = (x[31] == y[31]) ? (mb << d) + ms : (mb << d) - ms;
    end else begin
      exp2 = eb - 153;
      sum  = (x[31] == y[31]) ? (mb << 3) + 64'(ms != 0) : (mb << 3) - 64'(ms != 0);
    end
    if (sum == 0) return {x[31] & y[31], 31'd0};
    return pack_fp32(big[31], exp2, sum);
  endfunction

  function automatic logic [15:0] fp32_to_fp16(logic [31:0] x);
    logic [7:0]      ex;
    longint unsigned m;
    int              e;
    longint unsigned h;
    ex = x[30:23];
    m  = 64'({1'b1, x[22:0]});
    e  = int'(ex) - 127;
    if (ex == 8'hFF) begin
      if (x[22:0] != 23'd0) return {x[31], 5'h1F, 1'b1, x[21:13]};
      return {x[31], 15'h7C00};
    end
    if (ex == 8'd0 || e < -40) return {x[31], 15'd0};
    if (e > 15) return {x[31], 15'h7C00};
    if (e >= -14) begin
      h = (longint'(e + 14) << 10) + shr_even(m, 13);
      if (h >= 64'h7C00) h = 64'h7C00;
    end else begin
      h = (13 - 14 - e > 25) ? 64'd0 : shr_even(m, 13 - 14 - e);
    end
    return {x[31], h[14:0]};
  endfunction

  function automatic rotated_pair_t rotate_pair(logic [31:0] a, logic [31:0] b,
                                                logic [31:0] c, logic [31:0] s);
    rotated_pair_t r;
    if (convert_mode) begin
      r.first  = {16'd0, fp32_to_fp16(a)};
      r.second = {16'd0, fp32_to_fp16(b)};
      return r;
    end
    r.first  = fp32_add(fp32_mul(a, c), fp32_mul(b, s) ^ 32'h8000_0000);
    r.second = fp32_add(fp32_mul(a, s), fp32_mul(b, c));
    if (is_nan(r.first))  r.first  = CANON_NAN;
    if (is_nan(r.second)) r.second = CANON_NAN;
    if (half_mode) begin
      r.first  = {16'd0, fp32_to_fp16(r.first)};
      r.second = {16'd0, fp32_to_fp16(r.second)};
    end
    return r;
  endfunction

  // ----------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %08h expected %08h at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk) begin
    rotated_pair_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected beat", result_ch.first_out, 32'd0);
      end else begin
        want = pending_pairs.pop_front();
        if (result_ch.first_out !== want.first)
          report_mismatch("first_out", result_ch.first_out, want.first);
        if (result_ch.second_out !== want.second)
          report_mismatch("second_out", result_ch.second_out, want.second);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready = 1'b0;
    end else begin
      result_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ----------------------------------------------------------------- stimulus
  task automatic send_pair(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    pair_ch.valid     = 1'b1;
    pair_ch.first_in  = a;
    pair_ch.second_in = b;
    pair_ch.cos_value = c;
    pair_ch.sin_value = s;
    do @(posedge clk); while (!pair_ch.ready);
    pending_pairs.push_back(rotate_pair(a, b, c, s));
    @(negedge clk);
    pair_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    wait_drained();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_HALF_OUTPUT)  half_mode    = value[0];
    if (idx == REG_CONVERT_ONLY) convert_mode = value[0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_mode(logic half, logic conv);
    write_reg(REG_HALF_OUTPUT, {16'($urandom_range(0, 65535)), 15'd0, half});
    write_reg(REG_CONVERT_ONLY, {31'($urandom()), 1'b0} | {31'd0, conv});
  endtask

  function automatic logic [31:0] pick_special();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      5: return {1'($urandom_range(0, 1)), 8'h00, 23'($urandom())};
      6: return {1'($urandom_range(0, 1)), 31'h7F7F_FFFF};
      7: return {1'($urandom_range(0, 1)), 8'd1, 23'($urandom())};
      8: return {1'($urandom_range(0, 1)), 8'd142, 10'h3FF, 13'($urandom())};
      default: return {1'($urandom_range(0, 1)), 8'($urandom_range(98, 113)),
                       23'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2:    return pick_special();
      3:    return {1'($urandom_range(0, 1)), 8'($urandom_range(200, 254)), 23'($urandom())};
      4:    return {1'($urandom_range(0, 1)), 8'($urandom_range(1, 60)), 23'($urandom())};
      default: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 145)),
                       23'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] pick_trig();
    case ($urandom_range(0, 9))
      0: return pick_value();
      1: return {1'($urandom_range(0, 1)), 31'h3F80_0000};
      default: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 126)),
                       23'($urandom())};
    endcase
  endfunction

  task automatic send_random_pairs(int count);
    logic [31:0] a, b, c, s;
    for (int i = 0; i < count; i++) begin
      a = pick_value();
      b = ($urandom_range(0, 7) == 0) ? a ^ {1'($urandom_range(0, 1)), 31'd0} : pick_value();
      c = pick_trig();
      s = ($urandom_range(0, 7) == 0) ? c : pick_trig();
      send_pair(a, b, c, s);
    end
  endtask

  // --------------------------------------------------------------------- tests
  task automatic test_directed_rotate();
    set_mode(1'b0, 1'b0);
    send_pair(32'h3F80_0000, 32'h4000_0000, 32'h3F80_0000, 32'h0000_0000);
    send_pair(32'h3F80_0000, 32'h3F80_0000, 32'h3F35_04F3, 32'h3F35_04F3);
    send_pair(32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    send_pair(32'h8000_0000, 32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_pair(32'h7F80_0000, 32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000);
    send_pair(32'h7F80_0000, 32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_pair(32'h7FA0_1234, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_pair(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFC0_0001);
    send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hBF80_0000);
    send_pair(32'h0000_0001, 32'h007F_FFFF, 32'h3F00_0000, 32'h3F80_0000);
    send_pair(32'h0080_0000, 32'h0080_0000, 32'h3F00_0000, 32'h3F00_0000);
    send_pair(32'h3F80_0001, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_pair(32'h4B80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'hB380_0000);
  endtask

  task automatic test_half_output();
    set_mode(1'b1, 1'b0);
    send_pair(32'h477F_F000, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000);
    send_pair(32'h4780_0000, 32'h3880_0000, 32'h3F80_0000, 32'h0000_0000);
    send_pair(32'h3380_0000, 32'h3300_0001, 32'h3F80_0000, 32'h0000_0000);
    send_pair(32'h7F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000);
    send_pair(32'h3F80_1000, 32'h3F80_3000, 32'h3F80_0000, 32'h0000_0000);
    send_random_pairs(250);
  endtask

  task automatic test_convert_only();
    set_mode(1'b1, 1'b1);
    send_pair(32'h7FA0_2000, 32'hFFFF_FFFF, 32'h7FC0_0000, 32'h7F80_0000);
    send_pair(32'h7F80_0000, 32'hFF80_0000, 32'd0, 32'd0);
    send_pair(32'h0000_0001, 32'h8080_0000, $urandom(), $urandom());
    set_mode(1'b0, 1'b1);
    send_pair(32'h3380_0000, 32'hB300_0000, $urandom(), $urandom());
    send_pair(32'h477F_F000, 32'h4780_0000, $urandom(), $urandom());
    send_random_pairs(150);
  endtask

  task automatic test_random_phases();
    set_mode(1'b0, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_pairs(250);
    send_idle_pct = 63;
    send_random_pairs(150);
    set_mode(1'b1, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    send_random_pairs(150);
    set_mode(1'b0, 1'b0);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    send_random_pairs(100);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 80;
    send_random_pairs(40);
    wait_drained();
    send_random_pairs(20);
    write_reg(REG_UNUSED, $urandom());
    send_random_pairs(20);
  endtask

  initial begin
    pair_ch.valid     = 1'b0;
    pair_ch.first_in  = 32'd0;
    pair_ch.second_in = 32'd0;
    pair_ch.cos_value = 32'd0;
    pair_ch.sin_value = 32'd0;
    result_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_HALF_OUTPUT;
    cfg_ch.data       = 32'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_rotate();
    test_half_output();
    test_convert_only();
    test_random_phases();
    test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rope_pkg.sv
rtl/core/rope_if.sv
rtl/core/rotary_embedding_pair_rotate_top.sv
bench/rotary_embedding_pair_rotate_top_test.sv
